>>> sv/assert_macros.svh
// Assertion macros used by the checker file of this block.
// No dependencies; take it in with a plain include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Check a property at every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

>>> sv/bbi2c_pkg.sv
// Package for the bit-banged I2C cartridge slave: widths, codes, config type.
// No dependencies; the design files and the checker use it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package bbi2c_pkg;

   localparam int DATA_W = 8;
   localparam int PTR_W  = 16;
   localparam int SIZE_W = 17;
   localparam int CNT_W  = 4;
   localparam int STAT_W = 5;

   localparam int CART_DEPTH_DEFAULT = 65536;

   // request commands
   localparam logic CMD_SERIAL = 1'b0;
   localparam logic CMD_LOAD   = 1'b1;

   // configuration register indexes
   localparam logic CSR_PRESENT = 1'b0;
   localparam logic CSR_SIZE    = 1'b1;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 17'h10000;

   // device address byte decode
   localparam logic [DATA_W-1:0] DEV_RW_MASK = 8'hF1;
   localparam logic [DATA_W-1:0] DEV_WRITE   = 8'hA0;
   localparam logic [DATA_W-1:0] DEV_READ    = 8'hA1;
   localparam logic [3:0]        DEV_FAMILY  = 4'hA;

   // bit-counter codes
   localparam logic [3:0] CNT_START = 4'd15;
   localparam logic [3:0] CNT_ACK   = 4'd7;

   typedef struct packed {
      logic              present;
      logic [SIZE_W-1:0] size;
   } cfg_type;

endpackage

`default_nettype wire

>>> sv/bitbang_i2c_cartridge_slave_top.sv
// Top level of the bit-banged I2C cartridge slave: handshakes, config, result.
// Depends on bbi2c_pkg, bbi2c_store and bbi2c_engine.
`timescale 1ns / 1ps
`default_nettype none

// A host drives this slave one request per bus write: a serial request
// carries a control byte (bit 6 SCL, bit 7 SDA), a load request writes one
// cartridge byte at req_load_address. Every request returns one response,
// the slave's input shift register, in the cycle after it is accepted. The
// block takes one request every clock cycle; the response register sits
// between the two sides, so a new request enters while the last response
// waits, and only a full response register with rsp_ready low stalls it.
// The store is a single memory with one write and one registered read port;
// the read port fetches the byte at the pointer value for the next cycle,
// so a read-mode bit finds its byte ready with no wait. The store has no
// reset and no clearing pass: bytes must be loaded before they are read.
// CART_DEPTH is a power of two; pointer and load addresses wrap at it.
// Configuration is written through csr_we/csr_index/csr_wdata while idle.
module bitbang_i2c_cartridge_slave_top #(
   parameter int CART_DEPTH = bbi2c_pkg::CART_DEPTH_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_cmd,
   input  wire logic [bbi2c_pkg::DATA_W-1:0]  req_value,
   input  wire logic [bbi2c_pkg::PTR_W-1:0]   req_load_address,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic      [bbi2c_pkg::DATA_W-1:0]  rsp_serial_in,
   input  wire logic                          csr_we,
   input  wire logic                          csr_index,
   input  wire logic [bbi2c_pkg::SIZE_W-1:0]  csr_wdata
);

   localparam int ADDR_W = $clog2(CART_DEPTH);

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [bbi2c_pkg::DATA_W-1:0]  rsp_data_ff,  rsp_data_in;
   logic                          present_ff,   present_in;
   logic [bbi2c_pkg::SIZE_W-1:0]  size_ff,      size_in;

   logic                          req_fire;
   logic                          step_en;
   logic                          load_en;
   bbi2c_pkg::cfg_type            cfg;
   logic [bbi2c_pkg::DATA_W-1:0]  mem_rdata;
   logic [bbi2c_pkg::DATA_W-1:0]  shift_next;
   logic [bbi2c_pkg::PTR_W-1:0]   ptr_next;

   // take a request whenever the response slot is free or drains this cycle
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign step_en   = req_fire && (req_cmd == bbi2c_pkg::CMD_SERIAL);
   assign load_en   = req_fire && (req_cmd == bbi2c_pkg::CMD_LOAD);

   assign cfg.present = present_ff;
   assign cfg.size    = size_ff;

   // configuration registers; indexes outside the list are dropped
   always_comb begin
      present_in = present_ff;
      size_in    = size_ff;
      if (csr_we) begin
         case (csr_index)
            bbi2c_pkg::CSR_PRESENT: present_in = csr_wdata[0];
            bbi2c_pkg::CSR_SIZE:    size_in    = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // hold the response until taken, load a new one on every request
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_fire) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = shift_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         present_ff   <= 1'b0;
         size_ff      <= bbi2c_pkg::SIZE_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         present_ff   <= present_in;
         size_ff      <= size_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   bbi2c_store #(
      .CART_DEPTH (CART_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (load_en),
      .wr_addr (ADDR_W'(req_load_address)),
      .wr_data (req_value),
      .rd_addr (ADDR_W'(ptr_next)),
      .rd_data (mem_rdata)
   );

   bbi2c_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .step_en    (step_en),
      .value      (req_value),
      .cfg        (cfg),
      .mem_rdata  (mem_rdata),
      .shift_next (shift_next),
      .ptr_next   (ptr_next)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_serial_in = rsp_data_ff;

endmodule

`default_nettype wire

>>> sv/bbi2c_store.sv
// Cartridge byte store: one write port, one read port with registered data.
// Depends on bbi2c_pkg; a write to the address being read is forwarded.
`timescale 1ns / 1ps
`default_nettype none

module bbi2c_store #(
   parameter int CART_DEPTH = bbi2c_pkg::CART_DEPTH_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          wr_en,
   input  wire logic [$clog2(CART_DEPTH)-1:0] wr_addr,
   input  wire logic [bbi2c_pkg::DATA_W-1:0]  wr_data,
   input  wire logic [$clog2(CART_DEPTH)-1:0] rd_addr,
   output logic      [bbi2c_pkg::DATA_W-1:0]  rd_data
);

   logic [bbi2c_pkg::DATA_W-1:0] cart_mem [CART_DEPTH];
   logic [bbi2c_pkg::DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         cart_mem[wr_addr] <= wr_data;
      end
   end

   // forward a same-cycle write so the read always shows the latest byte
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= cart_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> sv/bbi2c_engine.sv
// Bus engine: SCL/SDA sampling, start/stop, bit counting, ack, address capture
// and read streaming. Depends on bbi2c_pkg; store data arrives prefetched.
`timescale 1ns / 1ps
`default_nettype none

module bbi2c_engine (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         step_en,
   input  wire logic [bbi2c_pkg::DATA_W-1:0] value,
   input  wire bbi2c_pkg::cfg_type           cfg,
   input  wire logic [bbi2c_pkg::DATA_W-1:0] mem_rdata,
   output logic      [bbi2c_pkg::DATA_W-1:0] shift_next,
   output logic      [bbi2c_pkg::PTR_W-1:0]  ptr_next
);

   logic                          scl_ff,    scl_in;
   logic                          sda_ff,    sda_in;
   logic [bbi2c_pkg::DATA_W-1:0]  shift_ff,  shift_in;
   logic [bbi2c_pkg::STAT_W-1:0]  status_ff, status_in;
   logic [bbi2c_pkg::DATA_W-1:0]  dev_ff,    dev_in;
   logic [bbi2c_pkg::PTR_W-1:0]   ptr_ff,    ptr_in;
   logic [bbi2c_pkg::CNT_W-1:0]   bits_ff,   bits_in;
   logic [bbi2c_pkg::DATA_W-1:0]  rshift_ff, rshift_in;

   always_comb begin
      logic                         addr_latched;
      logic                         dev_wr;
      logic                         cart_read;
      logic                         ack_phase;
      logic [bbi2c_pkg::DATA_W-1:0] sh;
      logic [bbi2c_pkg::DATA_W-1:0] rs;
      logic [bbi2c_pkg::CNT_W-1:0]  bt;
      logic [bbi2c_pkg::SIZE_W-1:0] ptr_inc;

      scl_in    = scl_ff;
      sda_in    = sda_ff;
      shift_in  = shift_ff;
      status_in = status_ff;
      dev_in    = dev_ff;
      ptr_in    = ptr_ff;
      bits_in   = bits_ff;
      rshift_in = rshift_ff;

      addr_latched = status_ff[4];
      dev_wr       = (dev_ff & bbi2c_pkg::DEV_RW_MASK) == bbi2c_pkg::DEV_WRITE;
      cart_read    = (dev_ff & bbi2c_pkg::DEV_RW_MASK) == bbi2c_pkg::DEV_READ;
      ack_phase    = status_ff[3:0] == bbi2c_pkg::CNT_ACK;
      sh           = {shift_ff[6:0], sda_ff};
      rs           = rshift_ff;
      bt           = bits_ff;
      ptr_inc      = {1'b0, ptr_ff} + 17'd1;

      if (step_en && value[6]) begin
         if (scl_ff) begin
            // SDA edge with SCL high: falling is start, rising is stop
            if (value[7] != sda_ff) begin
               status_in = value[7] ? '0 : {1'b0, bbi2c_pkg::CNT_START};
            end
         end else begin
            if (ack_phase) begin
               if (cfg.present && (dev_ff[7:4] == bbi2c_pkg::DEV_FAMILY)) begin
                  if (addr_latched) begin
                     if (dev_wr) begin
                        sh[0] = 1'b0;
                     end
                  end else begin
                     sh[0]        = 1'b0;
                     status_in[4] = 1'b1;
                     if (dev_wr) begin
                        ptr_in  = {13'd0, dev_ff[3:1]};
                        bits_in = '0;
                     end
                  end
               end
               status_in[3] = 1'b1;
            end else begin
               if (addr_latched && cart_read) begin
                  // fetch the next byte once the previous one is shifted out
                  if (bt == '0) begin
                     rs     = mem_rdata;
                     ptr_in = (ptr_inc >= cfg.size) ? '0 : ptr_inc[15:0];
                     bt     = 4'd8;
                  end
                  sh[0]     = sh[0] & rs[7];
                  rshift_in = {rs[6:0], 1'b0};
                  bits_in   = bt - 4'd1;
               end
               if (status_ff[2:0] == 3'd0) begin
                  if (addr_latched) begin
                     if (dev_wr) begin
                        ptr_in = {ptr_ff[7:0], sh};
                     end
                  end else begin
                     dev_in = sh;
                  end
               end
               status_in = status_ff - 5'd1;
            end
            shift_in = sh;
         end
      end

      if (step_en) begin
         scl_in = value[6];
         sda_in = value[7];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scl_ff    <= 1'b0;
         sda_ff    <= 1'b0;
         shift_ff  <= '0;
         status_ff <= '0;
         dev_ff    <= '0;
         ptr_ff    <= '0;
         bits_ff   <= '0;
         rshift_ff <= '0;
      end else begin
         scl_ff    <= scl_in;
         sda_ff    <= sda_in;
         shift_ff  <= shift_in;
         status_ff <= status_in;
         dev_ff    <= dev_in;
         ptr_ff    <= ptr_in;
         bits_ff   <= bits_in;
         rshift_ff <= rshift_in;
      end
   end

   assign shift_next = shift_in;
   // the store prefetches at the pointer the next cycle will hold
   assign ptr_next   = reset ? '0 : ptr_in;

endmodule

`default_nettype wire

>>> sv/bbi2c_checker.sv
// Port-level checker for the cartridge slave top, bound to every instance.
// Depends on bbi2c_pkg, assert_macros.svh and the top level's port names.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module bbi2c_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_valid,
   input wire logic                         req_ready,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_ready,
   input wire logic [bbi2c_pkg::DATA_W-1:0] rsp_serial_in
);

   // reset empties the response slot
   `ASSERT_ALWAYS(a_reset_empties, clock, reset |=> !rsp_valid)

   // an empty response slot never stalls a request
   `ASSERT_CLK(a_ready_when_empty, clock, reset, !rsp_valid |-> req_ready)

   // every accepted request shows a response next cycle
   `ASSERT_CLK(a_request_answers, clock, reset, (req_valid && req_ready) |=> rsp_valid)

   // a stalled response holds its value
   `ASSERT_CLK(a_rsp_holds, clock, reset,
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_serial_in)))

endmodule

bind bitbang_i2c_cartridge_slave_top bbi2c_checker u_checker (.*);

`default_nettype wire
